[src/dna_two_bit_packer_macros.svh]
// ----------------------------------------------------------------------------
// dna two-bit packer assertion macros
// Shared concurrent assertion shorthands for the packer modules.
// ----------------------------------------------------------------------------
`ifndef DNA_TWO_BIT_PACKER_MACROS_SVH
`define DNA_TWO_BIT_PACKER_MACROS_SVH

// same-cycle implication
`define DTBP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DTBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/dtbp_pkg.sv]
// ----------------------------------------------------------------------------
// dtbp_pkg
// Types, constants and helper functions of the two-bit nucleotide packer.
// ----------------------------------------------------------------------------
package dtbp_pkg;

	localparam int MAX_BASES_DEF  = 2048;
	localparam int BASES_PER_WORD = 32;
	localparam int WORD_W         = 64;
	localparam int CODE_W         = 2;
	localparam int FILL_W         = 5;
	localparam int BASES_W        = 6;
	localparam int CHAR_W         = 8;
	// drain count field sized for the largest supported store
	localparam int CNT_MAX_W      = 12;
	localparam int QUEUE_DEPTH    = 2;
	localparam int PADDR_W        = 3;
	localparam int PDATA_W        = 32;

	localparam logic [CODE_W-1:0] COMP_MASK = 2'b10;

	// register index decoded from paddr[2]
	localparam logic REG_STRAND_MODE = 1'b0;

	typedef enum logic {
		MODE_FORWARD = 1'b0,
		MODE_REVCOMP = 1'b1
	} strand_mode_t;

	typedef enum logic {
		CMD_WORD  = 1'b0,
		CMD_DRAIN = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		logic [CHAR_W-1:0] base_char;
		logic              last_char;
	} char_req_t;

	typedef struct packed {
		logic [WORD_W-1:0]  packed_word;
		logic [BASES_W-1:0] bases_in_word;
		logic               last_word;
		logic               overflowed;
	} word_req_t;

	// word: finished forward word, or the partial top word of a drain
	typedef struct packed {
		cmd_kind_t            kind;
		logic [WORD_W-1:0]    word;
		logic [BASES_W-1:0]   bases;
		logic                 last;
		logic [CNT_MAX_W-1:0] count;
		logic                 overflowed;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	function automatic logic [CODE_W-1:0] base_code(input logic [CHAR_W-1:0] c);
		return c[2:1];
	endfunction

	// base p of the result takes base 31-p of the input
	function automatic logic [WORD_W-1:0] reverse_codes(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] r;
		r = '0;
		for (int p = 0; p < BASES_PER_WORD; p++) begin
			r[CODE_W*p +: CODE_W] = w[CODE_W*(BASES_PER_WORD-1-p) +: CODE_W];
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] code_mask(input logic [BASES_W-1:0] bases);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int p = 0; p < BASES_PER_WORD; p++) begin
			if (BASES_W'(p) < bases) begin
				m[CODE_W*p +: CODE_W] = '1;
			end
		end
		return m;
	endfunction

endpackage

[src/dtbp_ram.sv]
// ----------------------------------------------------------------------------
// dtbp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dtbp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[src/dtbp_queue.sv]
// ----------------------------------------------------------------------------
// dtbp_queue
// Short command queue between the packing front and the output back.
// ----------------------------------------------------------------------------
`include "dna_two_bit_packer_macros.svh"

module dtbp_queue
	import dtbp_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  cmd_t        push_cmd,
	input  logic        pop,
	output cmd_t        head,
	output queue_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	assign head       = entries_q[rd_ptr_q];
	assign stat.full  = (fill_q == CNT_W'(DEPTH));
	assign stat.empty = (fill_q == '0);

	`DTBP_ASSERT_IMPL(a_no_push_full, clk, arst_n, push, !stat.full, "push into full queue")
	`DTBP_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, pop, !stat.empty, "pop from empty queue")

endmodule

[src/dtbp_front.sv]
// ----------------------------------------------------------------------------
// dtbp_front
// Takes characters, packs forward words, gathers reverse-complement words
// into the store and queues output or drain commands.
// ----------------------------------------------------------------------------
`include "dna_two_bit_packer_macros.svh"

module dtbp_front
	import dtbp_pkg::*;
#(
	parameter int MAX_BASES   = MAX_BASES_DEF,
	parameter int STORE_WORDS = (MAX_BASES + BASES_PER_WORD - 1) / BASES_PER_WORD,
	parameter int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_stall,
	input  char_req_t         char_data,
	input  strand_mode_t      strand_mode,
	input  queue_stat_t       q_stat,
	output logic              push,
	output cmd_t              push_cmd,
	input  logic              drain_done,
	output logic              wr_en,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [WORD_W-1:0] wr_data
);

	localparam int CNT_W = $clog2(MAX_BASES + 1);

	logic [WORD_W-1:0] fwd_acc_q;
	logic [FILL_W-1:0] fwd_fill_q;
	logic [WORD_W-1:0] rev_acc_q;
	logic [CNT_W-1:0]  rev_cnt_q;
	logic              ovf_q;
	logic              busy_q;

	logic              accept;
	logic              is_rev;
	logic [CODE_W-1:0] code;
	logic [WORD_W-1:0] fwd_acc_n;
	logic              fwd_emit;
	logic [WORD_W-1:0] rev_acc_n;
	logic              store_ok;
	logic              rev_full;
	logic [CNT_W-1:0]  rev_cnt_n;

	assign is_rev     = (strand_mode == MODE_REVCOMP);
	// reverse characters wait while a drain owns the store
	assign char_stall = q_stat.full || (is_rev && busy_q);
	assign accept     = char_valid && !char_stall;
	assign code       = base_code(char_data.base_char);

	always_comb begin
		fwd_acc_n = fwd_acc_q;
		fwd_acc_n[{fwd_fill_q, 1'b0} +: CODE_W] = code;
		rev_acc_n = rev_acc_q;
		rev_acc_n[{rev_cnt_q[FILL_W-1:0], 1'b0} +: CODE_W] = code ^ COMP_MASK;
	end

	assign fwd_emit  = (fwd_fill_q == FILL_W'(BASES_PER_WORD - 1)) || char_data.last_char;
	assign store_ok  = (rev_cnt_q < CNT_W'(MAX_BASES));
	assign rev_full  = store_ok && (rev_cnt_q[FILL_W-1:0] == FILL_W'(BASES_PER_WORD - 1));
	assign rev_cnt_n = rev_cnt_q + CNT_W'(store_ok);

	assign wr_en   = accept && is_rev && rev_full;
	assign wr_addr = ADDR_W'(rev_cnt_q >> FILL_W);
	assign wr_data = rev_acc_n;

	assign push = accept && (is_rev ? char_data.last_char : fwd_emit);

	always_comb begin
		push_cmd            = '0;
		push_cmd.last       = char_data.last_char;
		if (is_rev) begin
			push_cmd.kind       = CMD_DRAIN;
			push_cmd.word       = rev_acc_n;
			push_cmd.count      = CNT_MAX_W'(rev_cnt_n);
			push_cmd.overflowed = ovf_q || !store_ok;
		end else begin
			push_cmd.kind  = CMD_WORD;
			push_cmd.word  = fwd_acc_n;
			push_cmd.bases = BASES_W'(fwd_fill_q) + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_acc_q  <= '0;
			fwd_fill_q <= '0;
			rev_acc_q  <= '0;
			rev_cnt_q  <= '0;
			ovf_q      <= 1'b0;
			busy_q     <= 1'b0;
		end else begin
			if (drain_done) begin
				busy_q <= 1'b0;
			end
			if (accept && !is_rev) begin
				if (fwd_emit) begin
					fwd_acc_q  <= '0;
					fwd_fill_q <= '0;
				end else begin
					fwd_acc_q  <= fwd_acc_n;
					fwd_fill_q <= fwd_fill_q + 1'b1;
				end
			end
			if (accept && is_rev) begin
				if (char_data.last_char) begin
					rev_acc_q <= '0;
					rev_cnt_q <= '0;
					ovf_q     <= 1'b0;
					busy_q    <= 1'b1;
				end else begin
					rev_acc_q <= rev_full ? '0 : (store_ok ? rev_acc_n : rev_acc_q);
					rev_cnt_q <= rev_cnt_n;
					ovf_q     <= ovf_q || !store_ok;
				end
			end
		end
	end

	`DTBP_ASSERT_IMPL(a_busy_clear, clk, arst_n, $fell(busy_q), $past(drain_done), "busy cleared without drain end")

endmodule

[src/dtbp_back.sv]
// ----------------------------------------------------------------------------
// dtbp_back
// Executes queued commands: passes forward words out, drains the store
// as reverse-complement words, and holds the output register.
// ----------------------------------------------------------------------------
`include "dna_two_bit_packer_macros.svh"

module dtbp_back
	import dtbp_pkg::*;
#(
	parameter int MAX_BASES   = MAX_BASES_DEF,
	parameter int STORE_WORDS = (MAX_BASES + BASES_PER_WORD - 1) / BASES_PER_WORD,
	parameter int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              head,
	input  queue_stat_t       q_stat,
	output logic              pop,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	input  logic [WORD_W-1:0] rd_data,
	output logic              drain_done,
	output logic              word_valid,
	input  logic              word_stall,
	output word_req_t         word_data
);

	localparam int CNT_W = $clog2(MAX_BASES + 1);
	localparam int RL_W  = $clog2(STORE_WORDS + 1);

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_DRAIN = 2'b10
	} back_state_t;

	back_state_t       state_q;
	logic              out_valid_q;
	word_req_t         out_q;
	logic [WORD_W-1:0] hi_q;
	logic [CNT_W-1:0]  rem_q;
	logic [FILL_W-1:0] shift_q;
	logic              ovf_q;
	logic [RL_W-1:0]   rd_left_q;
	logic              lo_ok_q;

	logic                load_ok;
	logic [CNT_W-1:0]    head_n;
	logic [RL_W-1:0]     head_m;
	logic [WORD_W-1:0]   lo;
	logic [2*WORD_W-1:0] joined;
	logic [WORD_W-1:0]   window;
	logic [BASES_W-1:0]  bases;
	logic                final_word;
	logic                emit;

	assign load_ok = !out_valid_q || !word_stall;
	assign head_n  = CNT_W'(head.count);
	assign head_m  = RL_W'(head_n >> FILL_W);

	// window of 32 codes starting at the sequence remainder
	assign lo         = lo_ok_q ? rd_data : '0;
	assign joined     = {hi_q, lo} >> {shift_q, 1'b0};
	assign window     = joined[WORD_W-1:0];
	assign bases      = (rem_q > CNT_W'(BASES_PER_WORD)) ? BASES_W'(BASES_PER_WORD)
		: BASES_W'(rem_q);
	assign final_word = (rem_q <= CNT_W'(BASES_PER_WORD));
	assign emit       = (state_q == S_DRAIN) && load_ok;
	assign drain_done = emit && final_word;

	assign pop = (state_q == S_IDLE) && !q_stat.empty && load_ok;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				if (pop && head.kind == CMD_DRAIN && head_m != '0) begin
					rd_en   = 1'b1;
					rd_addr = ADDR_W'(head_m - 1'b1);
				end
			end
			S_DRAIN: begin
				if (emit && rd_left_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = ADDR_W'(rd_left_q - 1'b1);
				end
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && head.kind == CMD_WORD) begin
			out_q.packed_word   <= head.word;
			out_q.bases_in_word <= head.bases;
			out_q.last_word     <= head.last;
			out_q.overflowed    <= 1'b0;
		end else if (emit) begin
			out_q.packed_word   <= reverse_codes(window) & code_mask(bases);
			out_q.bases_in_word <= bases;
			out_q.last_word     <= final_word;
			out_q.overflowed    <= ovf_q;
		end
		if (pop && head.kind == CMD_DRAIN) begin
			hi_q    <= head.word;
			rem_q   <= head_n;
			shift_q <= head_n[FILL_W-1:0];
			ovf_q   <= head.overflowed;
		end else if (emit) begin
			hi_q  <= lo;
			rem_q <= rem_q - CNT_W'(bases);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			rd_left_q   <= '0;
			lo_ok_q     <= 1'b0;
		end else begin
			if (word_valid && !word_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (head.kind == CMD_WORD) begin
							out_valid_q <= 1'b1;
						end else begin
							state_q   <= S_DRAIN;
							lo_ok_q   <= (head_m != '0);
							rd_left_q <= (head_m != '0) ? head_m - 1'b1 : '0;
						end
					end
				end
				S_DRAIN: begin
					if (emit) begin
						out_valid_q <= 1'b1;
						lo_ok_q     <= (rd_left_q != '0);
						if (rd_left_q != '0) begin
							rd_left_q <= rd_left_q - 1'b1;
						end
						if (final_word) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign word_valid = out_valid_q;
	assign word_data  = out_q;

	`DTBP_ASSERT_IMPL(a_drain_rem, clk, arst_n, state_q == S_DRAIN, rem_q != '0, "drain with no bases left")
	`DTBP_ASSERT_IMPL(a_full_inner, clk, arst_n, out_valid_q && !out_q.last_word, out_q.bases_in_word == BASES_W'(BASES_PER_WORD), "inner word not full")

endmodule

[src/dna_two_bit_packer.sv]
// ----------------------------------------------------------------------------
// dna_two_bit_packer
// Packs nucleotide characters into 64-bit words of 32 two-bit codes,
// forward or as the reverse complement of the whole sequence.
// ----------------------------------------------------------------------------
// Forward mode takes one character per cycle unless the command queue is full
// and puts out a word after every 32 characters and on the last one.
// Reverse-complement mode likewise takes one character per cycle into a
// store of ceil(MAX_BASES/32) words; the last character starts a drain that
// starts the store read, then puts out one word per cycle while the output
// is not stalled, ceil(n/32) words for n stored bases. Reverse characters
// of the next sequence are held off until that drain ends, since the store
// has one read and one write port. Characters beyond MAX_BASES are dropped
// and flagged on every drained word. The store needs no clearing after reset.
module dna_two_bit_packer
	import dtbp_pkg::*;
#(
	parameter int MAX_BASES = MAX_BASES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_stall,
	input  char_req_t          char_data,
	output logic               word_valid,
	input  logic               word_stall,
	output word_req_t          word_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int STORE_WORDS = (MAX_BASES + BASES_PER_WORD - 1) / BASES_PER_WORD;
	localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

	strand_mode_t      strand_mode_q;
	logic              reg_sel;
	queue_stat_t       q_stat;
	cmd_t              push_cmd;
	cmd_t              head;
	logic              push;
	logic              pop;
	logic              drain_done;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [WORD_W-1:0] rd_data;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1] == REG_STRAND_MODE);
	assign prdata  = reg_sel ? PDATA_W'(strand_mode_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strand_mode_q <= MODE_FORWARD;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			strand_mode_q <= strand_mode_t'(pwdata[0]);
		end
	end

	dtbp_front #(
		.MAX_BASES  (MAX_BASES),
		.STORE_WORDS(STORE_WORDS),
		.ADDR_W     (ADDR_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.strand_mode(strand_mode_q),
		.q_stat     (q_stat),
		.push       (push),
		.push_cmd   (push_cmd),
		.drain_done (drain_done),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	dtbp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.stat    (q_stat)
	);

	dtbp_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STORE_WORDS),
		.AW   (ADDR_W)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	dtbp_back #(
		.MAX_BASES  (MAX_BASES),
		.STORE_WORDS(STORE_WORDS),
		.ADDR_W     (ADDR_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.drain_done(drain_done),
		.word_valid(word_valid),
		.word_stall(word_stall),
		.word_data (word_data)
	);

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-bit nucleotide packer: a scripted opening
// with hand-checked words, sequences that end on a full word, a long output
// hold-off, then random sequences in both strand modes, with all other words
// scored against an in-bench copy of the packing behavior.
// ----------------------------------------------------------------------------
module tb_top;
	import dtbp_pkg::*;

	localparam int STORE_BASES  = MAX_BASES_DEF;
	localparam int SETTLE       = 8;
	localparam int LONG_HOLD    = 300;
	localparam int LIMIT        = 4000;
	localparam int RANDOM_ITEMS = 60;
	localparam int CALM_ITEMS   = 20;
	localparam int SCRIPT_LEN   = 25;
	localparam logic [PADDR_W-1:0] STRAND_MODE_ADDR = {REG_STRAND_MODE, 2'b00};

	typedef struct packed {
		logic      typed;
		word_req_t w;
	} hand_word_t;

	typedef struct {
		strand_mode_t      mode;
		logic [CHAR_W-1:0] ch;
		logic              is_last;
		logic              typed;
		logic [WORD_W-1:0] word;
	} script_row_t;

	logic               clk;
	logic               arst_n;
	logic               char_valid;
	logic               char_stall;
	char_req_t          char_data;
	logic               word_valid;
	logic               word_stall;
	word_req_t          word_data;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	dna_two_bit_packer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word_data  (word_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// packer state as the bench sees it
	strand_mode_t      cur_mode;
	logic [WORD_W-1:0] fwd_acc;
	int                fwd_fill;
	logic [WORD_W-1:0] rc_store [STORE_BASES/BASES_PER_WORD];
	int                rc_count;
	logic              rc_ovf;

	word_req_t  fresh_words[$];
	word_req_t  expected_words[$];
	hand_word_t hand_q[$];

	int   mismatches;
	int   quiet_cycles;
	logic no_idle;
	logic hold_off_req;

	logic [CHAR_W-1:0] nucleotides [8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};

	script_row_t script [SCRIPT_LEN] = '{
		'{MODE_FORWARD, "A",   1'b1, 1'b1, 64'd0},
		'{MODE_FORWARD, "C",   1'b1, 1'b1, 64'd1},
		'{MODE_FORWARD, "T",   1'b1, 1'b1, 64'd2},
		'{MODE_FORWARD, "G",   1'b1, 1'b1, 64'd3},
		'{MODE_FORWARD, 8'hFF, 1'b1, 1'b1, 64'd3},
		'{MODE_FORWARD, 8'h00, 1'b1, 1'b1, 64'd0},
		'{MODE_FORWARD, "g",   1'b0, 1'b0, 64'd0},
		'{MODE_FORWARD, "a",   1'b0, 1'b0, 64'd0},
		'{MODE_FORWARD, 8'h80, 1'b0, 1'b0, 64'd0},
		'{MODE_FORWARD, "c",   1'b1, 1'b0, 64'd0},
		'{MODE_REVCOMP, "A",   1'b1, 1'b1, 64'd2},
		'{MODE_REVCOMP, "C",   1'b1, 1'b1, 64'd3},
		'{MODE_REVCOMP, "T",   1'b1, 1'b1, 64'd0},
		'{MODE_REVCOMP, "G",   1'b1, 1'b1, 64'd1},
		'{MODE_REVCOMP, "N",   1'b0, 1'b0, 64'd0},
		'{MODE_REVCOMP, "a",   1'b0, 1'b0, 64'd0},
		'{MODE_REVCOMP, 8'h7F, 1'b1, 1'b0, 64'd0},
		// each mode keeps its partial sequence across mode changes
		'{MODE_FORWARD, "A",   1'b0, 1'b0, 64'd0},
		'{MODE_FORWARD, "C",   1'b0, 1'b0, 64'd0},
		'{MODE_REVCOMP, "T",   1'b0, 1'b0, 64'd0},
		'{MODE_REVCOMP, "G",   1'b1, 1'b0, 64'd0},
		'{MODE_FORWARD, "G",   1'b1, 1'b0, 64'd0},
		'{MODE_REVCOMP, "C",   1'b0, 1'b0, 64'd0},
		'{MODE_FORWARD, "T",   1'b1, 1'b0, 64'd0},
		'{MODE_REVCOMP, "A",   1'b1, 1'b0, 64'd0}
	};

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic void pack_char(input char_req_t req);
		logic [CODE_W-1:0] code;
		logic [WORD_W-1:0] w;
		int                n;
		int                done;
		int                nb;
		int                idx;
		code = CODE_W'(req.base_char >> 1);
		if (cur_mode == MODE_FORWARD) begin
			fwd_acc[CODE_W*fwd_fill +: CODE_W] = code;
			fwd_fill++;
			if (fwd_fill == BASES_PER_WORD || req.last_char) begin
				fresh_words.push_back('{fwd_acc, BASES_W'(fwd_fill), req.last_char, 1'b0});
				fwd_acc = '0;
				fwd_fill = 0;
			end
			return;
		end
		if (rc_count < STORE_BASES) begin
			rc_store[rc_count / BASES_PER_WORD][CODE_W*(rc_count % BASES_PER_WORD) +: CODE_W] =
				code ^ COMP_MASK;
			rc_count++;
		end else begin
			rc_ovf = 1'b1;
		end
		if (req.last_char) begin
			// drain newest base first, 32 per word
			n = rc_count;
			done = 0;
			while (done < n) begin
				nb = (n - done > BASES_PER_WORD) ? BASES_PER_WORD : n - done;
				w = '0;
				for (int p = 0; p < nb; p++) begin
					idx = n - 1 - done - p;
					w[CODE_W*p +: CODE_W] =
						rc_store[idx / BASES_PER_WORD][CODE_W*(idx % BASES_PER_WORD) +: CODE_W];
				end
				done += nb;
				fresh_words.push_back('{w, BASES_W'(nb), done >= n, rc_ovf});
			end
			rc_count = 0;
			rc_ovf = 1'b0;
		end
	endfunction

	function automatic void note_mismatch(input string what, input word_req_t want,
	                                      input word_req_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch (%s) expected: word=%h bases=%0d last=%b ovf=%b", what,
				want.packed_word, want.bases_in_word, want.last_word, want.overflowed);
			$display("mismatch (%s) actual:   word=%h bases=%0d last=%b ovf=%b", what,
				got.packed_word, got.bases_in_word, got.last_word, got.overflowed);
		end
	endfunction

	always @(posedge clk) begin : scoreboard
		hand_word_t hand;
		word_req_t  want;
		logic       char_take;
		logic       word_take;
		if (arst_n) begin
			char_take = char_valid && !char_stall;
			word_take = word_valid && !word_stall;
			if (char_take) begin
				hand = hand_q.pop_front();
				fresh_words.delete();
				pack_char(char_data);
				if (hand.typed) begin
					expected_words.push_back(hand.w);
				end else begin
					foreach (fresh_words[i]) expected_words.push_back(fresh_words[i]);
				end
			end
			if (word_take) begin
				if (expected_words.size() == 0) begin
					note_mismatch("unexpected word", '0, word_data);
				end else begin
					want = expected_words.pop_front();
					if (word_data.packed_word !== want.packed_word ||
					    word_data.bases_in_word !== want.bases_in_word ||
					    word_data.last_word !== want.last_word ||
					    word_data.overflowed !== want.overflowed) begin
						note_mismatch("word", want, word_data);
					end
				end
			end
			if (char_take || word_take) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// output side: short random stalls, or one long hold-off on request
	initial begin : word_sink
		int n;
		word_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				word_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				word_stall <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 7);
				word_stall <= 1'b1;
				repeat (n) @(posedge clk);
				word_stall <= 1'b0;
			end
		end
	end

	task automatic push_char(input logic [CHAR_W-1:0] ch, input logic is_last,
	                         input hand_word_t hand);
		hand_q.push_back(hand);
		char_valid <= 1'b1;
		char_data <= '{base_char: ch, last_char: is_last};
		do @(posedge clk); while (char_stall);
		if (!no_idle && $urandom_range(0, 9) == 0) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic set_mode(input strand_mode_t m);
		char_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		// a request with no word may still be in flight
		repeat (SETTLE) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= STRAND_MODE_ADDR;
		pwdata <= PDATA_W'(m);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		cur_mode = m;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata[0] !== logic'(m)) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch (strand_mode read) expected: %0d actual: %0d", m, prdata[0]);
			end
		end
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [CHAR_W-1:0] pick_char();
		if ($urandom_range(0, 3) != 0) begin
			return nucleotides[$urandom_range(0, 7)];
		end
		return CHAR_W'($urandom_range(0, 255));
	endfunction

	task automatic send_run(input int len, input logic close);
		for (int i = 0; i < len; i++) begin
			push_char(pick_char(), close && i == len - 1, '0);
		end
	endtask

	// random sequences; one in eight is left open and picked up later
	task automatic random_runs(input int quota);
		int sent;
		int r;
		int len;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(0, 3) == 0) begin
				set_mode(strand_mode_t'($urandom_range(0, 1)));
			end
			r = $urandom_range(0, 9);
			if (r < 7) begin
				len = $urandom_range(1, 40);
			end else if (r < 9) begin
				len = $urandom_range(41, 100);
			end else begin
				len = BASES_PER_WORD * $urandom_range(1, 3);
			end
			send_run(len, $urandom_range(0, 7) != 0);
			sent += len;
		end
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		char_valid <= 1'b0;
		char_data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cur_mode = MODE_FORWARD;
		fwd_acc = '0;
		fwd_fill = 0;
		rc_count = 0;
		rc_ovf = 1'b0;
		mismatches = 0;
		quiet_cycles = 0;
		no_idle = 1'b0;
		hold_off_req = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].mode != cur_mode) set_mode(script[i].mode);
			push_char(script[i].ch, script[i].is_last,
				'{script[i].typed, '{script[i].word, BASES_W'(1), 1'b1, 1'b0}});
		end

		// full word on the last character
		set_mode(MODE_FORWARD);
		send_run(BASES_PER_WORD, 1'b1);
		set_mode(MODE_REVCOMP);
		send_run(BASES_PER_WORD, 1'b1);
		send_run(2 * BASES_PER_WORD, 1'b1);

		// output held off while characters keep coming
		set_mode(MODE_FORWARD);
		no_idle = 1'b1;
		hold_off_req = 1'b1;
		send_run(100, 1'b1);
		no_idle = 1'b0;

		random_runs(RANDOM_ITEMS);

		no_idle = 1'b1;
		random_runs(CALM_ITEMS);

		char_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
